[hw/rtl/longest_common_substring_length_defines.svh]
// Assertion macros used by the RTL.
`ifndef LONGEST_COMMON_SUBSTRING_LENGTH_DEFINES_SVH
`define LONGEST_COMMON_SUBSTRING_LENGTH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LCSL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LCSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lcsl_pkg.sv]
package lcsl_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 7;
    localparam int RUN_W       = $clog2(MAX_PATTERN + 1);
    localparam int STEP_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int EXT_W       = (RUN_W > LEN_W) ? RUN_W : LEN_W;
    localparam int LEN_MAX     = (1 << LEN_W) - 1;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } src_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] longest_length;
        logic             pattern_overflow;
    } res_item_t;

    typedef struct packed {
        logic             new_pattern;
        logic             clear_row;
        logic             text;
        logic             drain;
        logic [SYM_W-1:0] symbol;
    } cell_ctrl_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [RUN_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return (ext > EXT_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(ext);
    endfunction

endpackage

[hw/rtl/longest_common_substring_length.sv]
// Channel | Port group                 | Payload
// --------+----------------------------+---------------------------------------
// source  | src_valid, src_stall       | src_item: kind, symbol, last
// result  | res_valid, res_stall       | res_item: longest_length, pattern_overflow
//
// Pattern and text bytes without last are taken one per cycle while src_stall is low.
// After a last text byte the best run is shifted down the row of cells one position
// per cycle before it reaches the result register.
// src_stall is high during that sweep; it also waits there while res_stall holds a result.
// Reset clears the count, flags, run row and best; stored pattern bytes are not reset.
`include "longest_common_substring_length_defines.svh"

module longest_common_substring_length (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  lcsl_pkg::src_item_t   src_item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output lcsl_pkg::res_item_t   res_item
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [lcsl_pkg::STEP_W-1:0]  step_reg;
    logic [lcsl_pkg::STEP_W-1:0]  step_next;
    logic [lcsl_pkg::RUN_W-1:0]   count_reg;
    logic [lcsl_pkg::RUN_W-1:0]   count_next;
    logic                         closed_reg;
    logic                         closed_next;
    logic                         overflow_reg;
    logic                         overflow_next;
    logic                         res_valid_reg;
    logic                         res_valid_next;
    lcsl_pkg::res_item_t          res_item_reg;
    lcsl_pkg::res_item_t          res_item_next;

    logic                         src_acc;
    logic                         load_acc;
    logic                         text_acc;
    logic [lcsl_pkg::RUN_W-1:0]   base;
    logic                         room;
    logic                         finish;
    lcsl_pkg::cell_ctrl_t         ctrl;
    logic [lcsl_pkg::MAX_PATTERN-1:0] wr_en;

    logic [lcsl_pkg::RUN_W-1:0]   run_w  [lcsl_pkg::MAX_PATTERN];
    logic [lcsl_pkg::RUN_W-1:0]   best_w [lcsl_pkg::MAX_PATTERN];

    assign src_stall = (state_reg == ST_DRAIN);
    assign src_acc   = src_valid && !src_stall;
    assign load_acc  = src_acc && (src_item.kind == lcsl_pkg::KIND_PATTERN);
    assign text_acc  = src_acc && (src_item.kind == lcsl_pkg::KIND_TEXT);
    assign base      = closed_reg ? '0 : count_reg;
    assign room      = (base < lcsl_pkg::RUN_W'(lcsl_pkg::MAX_PATTERN));
    assign finish    = (state_reg == ST_DRAIN)
                    && (step_reg == lcsl_pkg::STEP_W'(lcsl_pkg::MAX_PATTERN - 1))
                    && (!res_valid_reg || !res_stall);

    always_comb
    begin
        ctrl.new_pattern = load_acc && closed_reg;
        ctrl.clear_row   = (load_acc && closed_reg) || finish;
        ctrl.text        = text_acc;
        ctrl.drain       = (state_reg == ST_DRAIN);
        ctrl.symbol      = src_item.symbol;
    end

    genvar k;
    generate
        for (k = 0; k < lcsl_pkg::MAX_PATTERN; k++)
        begin : g_cell
            logic [lcsl_pkg::RUN_W-1:0] left_run;
            logic [lcsl_pkg::RUN_W-1:0] left_best;

            if (k == 0)
            begin : g_first
                assign left_run  = '0;
                assign left_best = '0;
            end
            else
            begin : g_rest
                assign left_run  = run_w[k-1];
                assign left_best = best_w[k-1];
            end

            assign wr_en[k] = load_acc && room && (base == lcsl_pkg::RUN_W'(k));

            lcsl_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .wr_en     (wr_en[k]),
                .left_run  (left_run),
                .left_best (left_best),
                .run       (run_w[k]),
                .best      (best_w[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        closed_next    = closed_reg;
        overflow_next  = overflow_reg;
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        if (load_acc)
        begin
            if (closed_reg)
            begin
                overflow_next = 1'b0;
                closed_next   = 1'b0;
            end
            if (room)
            begin
                count_next = base + lcsl_pkg::RUN_W'(1);
            end
            else
            begin
                count_next    = base;
                overflow_next = 1'b1;
            end
            if (src_item.last)
            begin
                closed_next = 1'b1;
            end
        end

        if (text_acc)
        begin
            closed_next = 1'b1;
            if (src_item.last)
            begin
                state_next = ST_DRAIN;
                step_next  = '0;
            end
        end

        if (state_reg == ST_DRAIN)
        begin
            if (step_reg != lcsl_pkg::STEP_W'(lcsl_pkg::MAX_PATTERN - 1))
            begin
                step_next = step_reg + lcsl_pkg::STEP_W'(1);
            end
            if (finish)
            begin
                state_next                     = ST_IDLE;
                res_valid_next                 = 1'b1;
                res_item_next.longest_length   =
                    lcsl_pkg::sat_len(best_w[lcsl_pkg::MAX_PATTERN-1]);
                res_item_next.pattern_overflow = overflow_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            closed_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            closed_reg    <= closed_next;
            overflow_reg  <= overflow_next;
            res_valid_reg <= res_valid_next;
            res_item_reg  <= res_item_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `LCSL_ASSERT_NEXT(a_last_text_drains, text_acc && src_item.last,
        state_reg == ST_DRAIN, "last text item did not start the sweep")
    `LCSL_ASSERT_NOW(a_len_bound, $rose(res_valid),
        res_item.longest_length <= lcsl_pkg::sat_len(count_reg),
        "result length exceeds stored pattern length")
    `LCSL_ASSERT_NOW(a_overflow_full, $rose(res_valid) && res_item.pattern_overflow,
        count_reg == lcsl_pkg::RUN_W'(lcsl_pkg::MAX_PATTERN),
        "overflow reported with pattern store not full")
    `LCSL_ASSERT_NEXT(a_finish_idle, finish,
        state_reg == ST_IDLE && res_valid, "sweep end did not deliver a result")

endmodule

[hw/rtl/lcsl_cell.sv]
module lcsl_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lcsl_pkg::cell_ctrl_t           ctrl,
    input  logic                           wr_en,
    input  logic [lcsl_pkg::RUN_W-1:0]     left_run,
    input  logic [lcsl_pkg::RUN_W-1:0]     left_best,
    output logic [lcsl_pkg::RUN_W-1:0]     run,
    output logic [lcsl_pkg::RUN_W-1:0]     best
);

    logic [lcsl_pkg::SYM_W-1:0] pat_reg;
    logic                       valid_reg;
    logic                       valid_next;
    logic [lcsl_pkg::RUN_W-1:0] run_reg;
    logic [lcsl_pkg::RUN_W-1:0] run_next;
    logic [lcsl_pkg::RUN_W-1:0] best_reg;
    logic [lcsl_pkg::RUN_W-1:0] best_next;
    logic [lcsl_pkg::RUN_W-1:0] run_calc;
    logic                       hit;

    assign hit      = valid_reg && (pat_reg == ctrl.symbol);
    assign run_calc = hit ? (left_run + lcsl_pkg::RUN_W'(1)) : '0;

    always_comb
    begin
        run_next   = run_reg;
        best_next  = best_reg;
        valid_next = valid_reg;
        if (ctrl.clear_row)
        begin
            run_next  = '0;
            best_next = '0;
        end
        else if (ctrl.text)
        begin
            run_next  = run_calc;
            best_next = (run_calc > best_reg) ? run_calc : best_reg;
        end
        else if (ctrl.drain)
        begin
            best_next = (left_best > best_reg) ? left_best : best_reg;
        end
        if (wr_en)
        begin
            valid_next = 1'b1;
        end
        else if (ctrl.new_pattern)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pat_reg <= ctrl.symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            run_reg   <= '0;
            best_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            run_reg   <= run_next;
            best_reg  <= best_next;
        end
    end

    assign run  = run_reg;
    assign best = best_reg;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import lcsl_pkg::*;

    localparam int ITEM_TARGET = 850;
    localparam int CALM_FROM   = 750;

    class substring_tracker;
        logic [SYM_W-1:0] pattern_mem [MAX_PATTERN];
        logic [RUN_W-1:0] run_row [MAX_PATTERN];
        logic [6:0]       stored;
        logic [RUN_W-1:0] best;
        bit               closed;
        bit               overflow;
        res_item_t        expected_lengths [$];
        int               errors;
        int               checked;

        function new();
            stored   = '0;
            closed   = 1'b0;
            overflow = 1'b0;
            errors   = 0;
            checked  = 0;
            clear_runs();
        endfunction

        function void clear_runs();
            foreach (run_row[k])
                run_row[k] = '0;
            best = '0;
        endfunction

        function void note_item(src_item_t it);
            logic [RUN_W-1:0] v;
            res_item_t        want;
            if (it.kind == KIND_PATTERN)
            begin
                if (closed)
                begin
                    stored   = '0;
                    overflow = 1'b0;
                    closed   = 1'b0;
                    clear_runs();
                end
                if (stored < MAX_PATTERN)
                begin
                    pattern_mem[stored] = it.symbol;
                    stored++;
                end
                else
                    overflow = 1'b1;
                if (it.last)
                    closed = 1'b1;
            end
            else
            begin
                closed = 1'b1;
                // walk downward so each cell still sees the previous row
                for (int k = MAX_PATTERN - 1; k >= 0; k--)
                begin
                    if (k < stored)
                    begin
                        v = '0;
                        if (pattern_mem[k] == it.symbol)
                            v = (k == 0) ? RUN_W'(1) : run_row[k - 1] + RUN_W'(1);
                        run_row[k] = v;
                        if (v > best)
                            best = v;
                    end
                end
                if (it.last)
                begin
                    want.longest_length   = LEN_W'(best);
                    want.pattern_overflow = overflow;
                    expected_lengths.push_back(want);
                    clear_runs();
                end
            end
        endfunction

        function void check_result(res_item_t got);
            res_item_t want;
            checked++;
            if (expected_lengths.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual len=%0d ovf=%0d",
                         $time, got.longest_length, got.pattern_overflow);
                errors++;
                return;
            end
            want = expected_lengths.pop_front();
            if (got.longest_length !== want.longest_length)
            begin
                $display("%0t: longest_length expected %0d actual %0d",
                         $time, want.longest_length, got.longest_length);
                errors++;
            end
            if (got.pattern_overflow !== want.pattern_overflow)
            begin
                $display("%0t: pattern_overflow expected %0d actual %0d",
                         $time, want.pattern_overflow, got.pattern_overflow);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    src_item_t src_item = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res_item;

    substring_tracker board = new();
    int               sent_count = 0;
    logic [SYM_W-1:0] alphabet [4];
    int               alpha_n = 0;

    longest_common_substring_length dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit idle_allowed();
        return (sent_count < CALM_FROM) && (sent_count % 128 >= 24);
    endfunction

    function automatic logic [SYM_W-1:0] pick_symbol();
        if (alpha_n == 0)
            return SYM_W'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, alpha_n - 1)];
    endfunction

    task automatic send_item(input logic kind, input logic [SYM_W-1:0] sym, input logic fin);
        src_item_t it;
        it.kind   = kind;
        it.symbol = sym;
        it.last   = fin;
        if (idle_allowed() && $urandom_range(0, 3) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= it;
        do
            @(posedge clk);
        while (src_stall);
        board.note_item(it);
        sent_count++;
    endtask

    task automatic send_pattern(input int len, input bit close);
        for (int i = 0; i < len; i++)
            send_item(KIND_PATTERN, pick_symbol(), close && (i == len - 1));
    endtask

    task automatic send_text(input int len, input bit close);
        for (int i = 0; i < len; i++)
            send_item(KIND_TEXT, pick_symbol(), close && (i == len - 1));
    endtask

    initial
    begin : stimulus
        int plen;
        int tlen;
        int texts;
        int waited;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // text with nothing stored
        send_item(KIND_TEXT, 8'h00, 1'b1);
        send_item(KIND_PATTERN, 8'h00, 1'b0);
        send_item(KIND_PATTERN, 8'hFF, 1'b0);
        send_item(KIND_PATTERN, 8'h00, 1'b1);
        send_item(KIND_TEXT, 8'hFF, 1'b0);
        send_item(KIND_TEXT, 8'h00, 1'b0);
        send_item(KIND_TEXT, 8'hFF, 1'b0);
        send_item(KIND_TEXT, 8'h00, 1'b1);
        send_item(KIND_TEXT, 8'h55, 1'b1);
        // abandon a text with a new pattern, then stream before it is closed
        send_item(KIND_TEXT, 8'h00, 1'b0);
        send_item(KIND_TEXT, 8'hFF, 1'b0);
        send_item(KIND_PATTERN, 8'hAA, 1'b0);
        send_item(KIND_PATTERN, 8'hBB, 1'b0);
        send_item(KIND_TEXT, 8'hAA, 1'b0);
        send_item(KIND_TEXT, 8'hBB, 1'b1);
        send_item(KIND_PATTERN, 8'h7F, 1'b1);
        send_item(KIND_TEXT, 8'h7F, 1'b1);
        send_item(KIND_TEXT, 8'h80, 1'b0);
        send_item(KIND_TEXT, 8'h7F, 1'b1);
        send_item(KIND_PATTERN, 8'h80, 1'b0);
        send_item(KIND_PATTERN, 8'h01, 1'b0);
        send_item(KIND_PATTERN, 8'hFE, 1'b1);
        send_item(KIND_TEXT, 8'h80, 1'b0);
        send_item(KIND_TEXT, 8'h01, 1'b0);
        send_item(KIND_TEXT, 8'hFE, 1'b1);

        // overfull pattern of one byte value, matched to full length
        alphabet[0] = 8'h3C;
        alpha_n     = 1;
        send_pattern(MAX_PATTERN + 2, 1'b1);
        send_text(MAX_PATTERN + 2, 1'b1);

        while (sent_count < ITEM_TARGET)
        begin
            for (int a = 0; a < 4; a++)
                alphabet[a] = SYM_W'($urandom_range(0, 255));
            alpha_n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72)
                                               : $urandom_range(1, 12);
            send_pattern(plen, $urandom_range(0, 9) != 0);
            texts = $urandom_range(1, 4);
            for (int t = 0; t < texts; t++)
            begin
                tlen = (plen >= 60) ? $urandom_range(30, 70) : $urandom_range(1, 20);
                send_text(tlen, $urandom_range(0, 11) != 0);
            end
        end
        src_valid <= 1'b0;

        waited = 0;
        while (board.expected_lengths.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (3 * MAX_PATTERN) @(posedge clk);
        if (board.expected_lengths.size() != 0)
        begin
            $display("%0t: %0d results expected, actual none",
                     $time, board.expected_lengths.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : result_side
        int  hold;
        bit  pressed;
        hold    = 0;
        pressed = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                board.check_result(res_item);
            if (hold > 0)
                hold--;
            else if (!pressed && board.checked >= 20)
            begin
                hold    = 400;
                pressed = 1'b1;
            end
            else if (idle_allowed() && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 15);
            res_stall <= (hold > 0);
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
